// File: sv/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, skipped while reset is held
`define OLAD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked every clock, reset included
`define OLAD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/olad_pkg.sv
// types and codes shared by the ordered list unit
package olad_pkg;

    // stream widths
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // most results one read out gives
    localparam int MAX_RESULTS = 16;

    // operation codes carried in s_tuser
    localparam logic [S_TUSER_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [S_TUSER_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [S_TUSER_W-1:0] FUNC_READ   = 2'd2;

    // result status codes carried in m_tuser
    typedef logic [M_TUSER_W-1:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_EMPTY     = 3'd3;
    localparam status_t ST_ELEM      = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic    mem_we;
        logic    wr_from_rd;
        logic    rd_en;
        logic    key_ld;
        logic    out_ld;
        status_t out_status;
        logic    out_elem_rd;
        logic    out_last;
    } olad_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic match;
        logic out_free;
    } olad_sts_t;

endpackage

// File: sv/ordered_list_append_delete_key_unit.sv
// Ordered list unit: append, delete first match, read out head to tail.
// Append and empty read out: item taken, result in the next cycle; an unused code is taken with no result.
// Delete: read and compare each entry to the key, then shift each entry behind the match toward the head.
// Read out: for each entry, a registered store read then the result load.
// A stalled result holds the sequence; a new item is taken only when idle.
// Reset clears the fill count and result valid; store contents are kept.
module ordered_list_append_delete_key_unit #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [olad_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0]
    input  logic [olad_pkg::S_TUSER_W-1:0]  s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [olad_pkg::M_TDATA_W-1:0]  m_tdata,   // element[31:0], position[35:32]
    output logic [olad_pkg::M_TUSER_W-1:0]  m_tuser,   // status[2:0]
    output logic                            m_tlast
);
    import olad_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    olad_cmd_t        cmd;
    olad_sts_t        sts;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] out_pos;

    // sequencer
    olad_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .out_pos (out_pos)
    );

    // storage and result register
    olad_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .out_pos (out_pos),
        .sts     (sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: sv/olad_dp.sv
// datapath: list store, key compare and result register
module olad_dp #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [olad_pkg::S_TDATA_W-1:0]  s_tdata,
    input  olad_pkg::olad_cmd_t             cmd,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    input  logic [olad_pkg::POS_W-1:0]      out_pos,
    output olad_pkg::olad_sts_t             sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [olad_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [olad_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import olad_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [VALUE_W-1:0] key_reg;
    logic [VALUE_W-1:0] wr_data;
    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] elem_reg;
    logic [POS_W-1:0]   pos_reg;
    status_t            status_reg;
    logic               last_reg;

    // write source: new value or the entry just read (shift toward head)
    assign wr_data = cmd.wr_from_rd ? rd_data_reg : s_tdata[VALUE_W-1:0];

    // list store with registered read, and the delete key
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.key_ld) begin
            key_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            elem_reg   <= cmd.out_elem_rd ? rd_data_reg : '0;
            pos_reg    <= cmd.out_elem_rd ? out_pos : '0;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    // status back to the controller
    assign sts.match    = (rd_data_reg == key_reg);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - POS_W){1'b0}}, pos_reg, elem_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// File: sv/olad_ctrl.sv
// controller: sequences append, delete scan and shift, and read out
module olad_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic [olad_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            s_tready,
    input  olad_pkg::olad_sts_t             sts,
    output olad_pkg::olad_cmd_t             cmd,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [olad_pkg::POS_W-1:0]      out_pos
);
    import olad_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RO_RD,
        S_RO_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_p1;
    logic             ro_last;

    assign idx_p1  = idx_reg + CNT_W'(1);
    // final read-out item: tail reached or result limit reached
    assign ro_last = (idx_p1 == fill_reg) || (32'(idx_reg) == 32'(MAX_RESULTS - 1));

    // next state and commands
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        cmd        = '0;
        wr_addr    = idx_reg[IDX_W-1:0];
        rd_addr    = idx_reg[IDX_W-1:0];
        out_pos    = POS_W'(idx_reg);
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    unique case (s_tuser)
                        FUNC_APPEND: begin
                            cmd.out_ld   = 1'b1;
                            cmd.out_last = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.mem_we     = 1'b1;
                                wr_addr        = fill_reg[IDX_W-1:0];
                                fill_next      = fill_reg + CNT_W'(1);
                                cmd.out_status = ST_OK;
                            end
                        end
                        FUNC_DELETE: begin
                            cmd.key_ld = 1'b1;
                            idx_next   = '0;
                            state_next = S_DEL_RD;
                        end
                        FUNC_READ: begin
                            if (fill_reg == '0) begin
                                cmd.out_ld     = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                idx_next   = '0;
                                state_next = S_RO_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // fetch the next entry to compare, or report a missing key
            S_DEL_RD: begin
                if (idx_reg >= fill_reg) begin
                    if (sts.out_free) begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_NOT_FOUND;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP: begin
                if (sts.match) begin
                    state_next = S_SH_RD;
                end else begin
                    idx_next   = idx_p1;
                    state_next = S_DEL_RD;
                end
            end
            // read the entry behind the gap, or finish the delete
            S_SH_RD: begin
                if (idx_p1 >= fill_reg) begin
                    if (sts.out_free) begin
                        fill_next      = fill_reg - CNT_W'(1);
                        cmd.out_ld     = 1'b1;
                        cmd.out_last   = 1'b1;
                        cmd.out_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = idx_p1[IDX_W-1:0];
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.mem_we     = 1'b1;
                cmd.wr_from_rd = 1'b1;
                idx_next       = idx_p1;
                state_next     = S_SH_RD;
            end
            S_RO_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RO_OUT;
            end
            // hand one entry to the result register
            S_RO_OUT: begin
                if (sts.out_free) begin
                    cmd.out_ld      = 1'b1;
                    cmd.out_status  = ST_ELEM;
                    cmd.out_elem_rd = 1'b1;
                    cmd.out_last    = ro_last;
                    if (ro_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_p1;
                        state_next = S_RO_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, index and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// File: sv/olad_chk.sv
// port-level checks for the ordered list unit, bound to the top level
`include "assert_macros.svh"

module olad_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [olad_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [olad_pkg::M_TUSER_W-1:0]  m_tuser
);
    import olad_pkg::*;

    logic                           out_stall;
    logic                           status_item;
    logic [M_TUSER_W+M_TDATA_W-1:0] m_word;

    // result waiting, status-only result, whole result word
    assign out_stall   = m_tvalid && !m_tready;
    assign status_item = m_tvalid && (m_tuser != ST_ELEM);
    assign m_word      = {m_tuser, m_tdata};

    // no item waits on the output right after reset
    `OLAD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // an item is taken only when the result register can be loaded
    `OLAD_ASSERT(a_in_needs_room, aclk, aresetn, s_tready |-> !out_stall, "ready while blocked")

    // results other than read-out entries carry zero element and position
    `OLAD_ASSERT(a_zero_payload, aclk, aresetn, status_item |-> m_tdata == '0, "payload not zero")

    // a stalled result holds
    `OLAD_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(m_word), "result moved")

endmodule

bind ordered_list_append_delete_key_unit olad_chk u_olad_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
